FILE: rtl/led_bit_pwm_encoder_assert.svh
// Assertion macros for the LED bit encoder.
`ifndef LED_BIT_PWM_ENCODER_ASSERT_SVH
`define LED_BIT_PWM_ENCODER_ASSERT_SVH
`ifndef SYNTH
`define LBPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lbpe: implication check failed");
`define LBPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbpe: next-cycle check failed");
`else
`define LBPE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LBPE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/lbpe_pkg.sv
package lbpe_pkg;

	localparam int MAX_HALF_WORDS_DEF = 256;
	localparam int BITS_PER_LED = 24;
	localparam int CNT_W = $clog2(BITS_PER_LED);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_LED - 1);
	localparam logic [1:0] LAST_BYTE = 2'd2;

	localparam int COLOR_W = 8;
	localparam int DUTY_W = 8;
	localparam int HALF_W = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [DUTY_W-1:0] DUTY_ZERO_RST = 8'd30;
	localparam logic [DUTY_W-1:0] DUTY_ONE_RST = 8'd60;
	localparam logic [7:0] BRIGHT_RST = 8'd255;
	localparam logic [7:0] TEMP_RST = 8'd255;
	localparam logic [HALF_W-1:0] HALF_RST = 9'd96;

	// Scaling: n = color * temp * bright, result = n / 65025.
	// q0 = (n * floor(2^32 / 65025)) >> 32 is q or q - 1; one compare fixes it.
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 17;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int Q_LSB = 32;
	localparam logic [MUL_B_W-1:0] RECIP = 17'd66051;
	localparam logic [MUL_B_W-1:0] DIVISOR = 17'd65025;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DUTY_ZERO,
		REG_DUTY_ONE,
		REG_BRIGHTNESS,
		REG_TEMP_FIRST,
		REG_TEMP_SECOND,
		REG_TEMP_THIRD,
		REG_HALF_WORDS
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EOF,
		ST_MUL_F,
		ST_MUL_N,
		ST_MUL_Q,
		ST_MUL_T,
		ST_ROUND,
		ST_EMIT
	} step_t;

	typedef enum logic [1:0] {WAIT_NONE, WAIT_IN, WAIT_OUT} wait_t;
	typedef enum logic [1:0] {MA_TEMP, MA_COLOR, MA_NQ, MA_QQ} mul_a_t;
	typedef enum logic [1:0] {MB_BRIGHT, MB_FQ, MB_RECIP, MB_DIV} mul_b_t;
	typedef enum logic [2:0] {LD_NONE, LD_START, LD_F, LD_N, LD_Q, LD_T, LD_BYTE} load_t;
	typedef enum logic [1:0] {EM_NONE, EM_BIT, EM_PAD} emit_t;
	typedef enum logic [1:0] {CD_ALWAYS, CD_LED, CD_BYTES, CD_BITS} cond_t;

	typedef struct packed {
		wait_t  wait_sel;
		mul_a_t mul_a;
		mul_b_t mul_b;
		load_t  load;
		emit_t  emit_sel;
		cond_t  cond;
		step_t  jump_t;
		step_t  jump_f;
	} ctrl_t;

	typedef struct packed {
		logic in_req;
		logic out_free;
		logic is_led;
		logic bytes_left;
		logic bits_left;
	} stat_t;

	// Control store.
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		w = '{WAIT_NONE, MA_TEMP, MB_BRIGHT, LD_NONE, EM_NONE, CD_ALWAYS, ST_IDLE, ST_IDLE};
		case (s)
			ST_IDLE: w = '{WAIT_IN, MA_TEMP, MB_BRIGHT, LD_START, EM_NONE, CD_LED,
				ST_MUL_F, ST_EOF};
			ST_EOF: w = '{WAIT_OUT, MA_TEMP, MB_BRIGHT, LD_NONE, EM_PAD, CD_ALWAYS,
				ST_IDLE, ST_IDLE};
			ST_MUL_F: w = '{WAIT_NONE, MA_TEMP, MB_BRIGHT, LD_F, EM_NONE, CD_ALWAYS,
				ST_MUL_N, ST_MUL_N};
			ST_MUL_N: w = '{WAIT_NONE, MA_COLOR, MB_FQ, LD_N, EM_NONE, CD_ALWAYS,
				ST_MUL_Q, ST_MUL_Q};
			ST_MUL_Q: w = '{WAIT_NONE, MA_NQ, MB_RECIP, LD_Q, EM_NONE, CD_ALWAYS,
				ST_MUL_T, ST_MUL_T};
			ST_MUL_T: w = '{WAIT_NONE, MA_QQ, MB_DIV, LD_T, EM_NONE, CD_ALWAYS,
				ST_ROUND, ST_ROUND};
			ST_ROUND: w = '{WAIT_NONE, MA_TEMP, MB_BRIGHT, LD_BYTE, EM_NONE, CD_BYTES,
				ST_MUL_F, ST_EMIT};
			ST_EMIT: w = '{WAIT_OUT, MA_TEMP, MB_BRIGHT, LD_NONE, EM_BIT, CD_BITS,
				ST_EMIT, ST_IDLE};
			default: w = '{WAIT_NONE, MA_TEMP, MB_BRIGHT, LD_NONE, EM_NONE, CD_ALWAYS,
				ST_IDLE, ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/lbpe_seq.sv
`include "led_bit_pwm_encoder_assert.svh"

module lbpe_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  lbpe_pkg::stat_t stat,
	output lbpe_pkg::ctrl_t ctrl,
	output logic           fire
);
	import lbpe_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  taken;

	always_comb begin
		ctrl = ucode(step_q);
		case (ctrl.wait_sel)
			WAIT_IN:  fire = stat.in_req;
			WAIT_OUT: fire = stat.out_free;
			default:  fire = 1'b1;
		endcase
	end

	always_comb begin
		case (ctrl.cond)
			CD_LED:   taken = stat.is_led;
			CD_BYTES: taken = stat.bytes_left;
			CD_BITS:  taken = stat.bits_left;
			default:  taken = 1'b1;
		endcase
		step_d = step_q;
		if (fire) begin
			step_d = taken ? ctrl.jump_t : ctrl.jump_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	`LBPE_ASSERT_NXT(a_emit_holds, clk, arst_n, step_q == ST_EMIT && !fire, step_q == ST_EMIT)
	`LBPE_ASSERT_NXT(a_round_exit, clk, arst_n, step_q == ST_ROUND, step_q == ST_MUL_F || step_q == ST_EMIT)

endmodule

FILE: rtl/lbpe_dp.sv
`include "led_bit_pwm_encoder_assert.svh"

module lbpe_dp #(
	parameter int MAX_HALF_WORDS = lbpe_pkg::MAX_HALF_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lbpe_pkg::ctrl_t               ctrl,
	input  logic                          fire,
	input  logic                          in_valid,
	input  logic                          action,
	input  logic [lbpe_pkg::COLOR_W-1:0]  color_first,
	input  logic [lbpe_pkg::COLOR_W-1:0]  color_second,
	input  logic [lbpe_pkg::COLOR_W-1:0]  color_third,
	input  logic [lbpe_pkg::DUTY_W-1:0]   duty_zero,
	input  logic [lbpe_pkg::DUTY_W-1:0]   duty_one,
	input  logic [7:0]                    brightness,
	input  logic [7:0]                    temp_first,
	input  logic [7:0]                    temp_second,
	input  logic [7:0]                    temp_third,
	input  logic [lbpe_pkg::HALF_W-1:0]   half_words,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [lbpe_pkg::DUTY_W-1:0]   duty,
	output logic [lbpe_pkg::HALF_W-1:0]   pad_count,
	output logic                          half_full,
	output logic                          last,
	output lbpe_pkg::stat_t               stat
);
	import lbpe_pkg::*;

	localparam int POS_W = ($clog2(MAX_HALF_WORDS) < HALF_W) ? $clog2(MAX_HALF_WORDS) : HALF_W;
	localparam int HW_W = HALF_W + 1;

	logic [COLOR_W-1:0] color_q [3];
	logic [1:0]         bsel_q;
	logic [CNT_W-1:0]   bit_cnt_q;
	logic [15:0]        f_q;
	logic [MUL_A_W-1:0] n_q;
	logic [7:0]         qq_q;
	logic [MUL_A_W-1:0] t_q;
	logic [MUL_A_W-1:0] bits_q;
	logic [POS_W-1:0]   pos_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [7:0]         temp_sel;
	logic [7:0]         scaled;
	logic [MUL_A_W-1:0] rem;
	logic [HW_W-1:0]    hw_eff;
	logic [HW_W-1:0]    pos_ext;
	logic [HW_W-1:0]    pos_inc;
	logic               wrap;
	logic [HALF_W-1:0]  pad;

	always_comb begin
		case (bsel_q)
			2'd0:    temp_sel = temp_first;
			2'd1:    temp_sel = temp_second;
			default: temp_sel = temp_third;
		endcase
		case (ctrl.mul_a)
			MA_TEMP:  mul_a = MUL_A_W'(temp_sel);
			MA_COLOR: mul_a = MUL_A_W'(color_q[bsel_q]);
			MA_NQ:    mul_a = n_q;
			default:  mul_a = MUL_A_W'(qq_q);
		endcase
		case (ctrl.mul_b)
			MB_BRIGHT: mul_b = MUL_B_W'(brightness);
			MB_FQ:     mul_b = MUL_B_W'(f_q);
			MB_RECIP:  mul_b = RECIP;
			default:   mul_b = DIVISOR;
		endcase
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// Estimate is low by at most one.
	assign rem = n_q - t_q;
	assign scaled = qq_q + 8'(rem >= MUL_A_W'(DIVISOR));

	always_comb begin
		if (half_words == '0) begin
			hw_eff = HW_W'(1);
		end else if (32'(half_words) > MAX_HALF_WORDS) begin
			hw_eff = HW_W'(MAX_HALF_WORDS);
		end else begin
			hw_eff = HW_W'(half_words);
		end
		pos_ext = HW_W'(pos_q);
		pos_inc = pos_ext + HW_W'(1);
		wrap = (pos_inc >= hw_eff);
		pad = (pos_ext < hw_eff) ? HALF_W'(hw_eff - pos_ext) : '0;
	end

	assign stat.in_req = in_valid;
	assign stat.out_free = !out_valid || !out_stall;
	assign stat.is_led = !action;
	assign stat.bytes_left = (bsel_q != LAST_BYTE);
	assign stat.bits_left = (bit_cnt_q != LAST_BIT);

	always_ff @(posedge clk) begin
		if (fire) begin
			case (ctrl.load)
				LD_START: begin
					color_q[0] <= color_first;
					color_q[1] <= color_second;
					color_q[2] <= color_third;
				end
				LD_F:    f_q <= prod[15:0];
				LD_N:    n_q <= prod[MUL_A_W-1:0];
				LD_Q:    qq_q <= prod[Q_LSB+7:Q_LSB];
				LD_T:    t_q <= prod[MUL_A_W-1:0];
				LD_BYTE: bits_q <= {bits_q[MUL_A_W-9:0], scaled};
				default: ;
			endcase
			if (ctrl.emit_sel == EM_BIT) begin
				bits_q <= {bits_q[MUL_A_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsel_q <= '0;
			bit_cnt_q <= '0;
		end else if (fire) begin
			if (ctrl.load == LD_START) begin
				bsel_q <= '0;
				bit_cnt_q <= '0;
			end else if (ctrl.load == LD_BYTE) begin
				bsel_q <= bsel_q + 2'd1;
			end
			if (ctrl.emit_sel == EM_BIT) begin
				bit_cnt_q <= bit_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (fire && ctrl.emit_sel == EM_BIT) begin
			pos_q <= wrap ? '0 : pos_inc[POS_W-1:0];
		end else if (fire && ctrl.emit_sel == EM_PAD) begin
			pos_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire && ctrl.emit_sel != EM_NONE) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctrl.emit_sel == EM_BIT) begin
			duty <= bits_q[MUL_A_W-1] ? duty_one : duty_zero;
			pad_count <= '0;
			half_full <= wrap;
			last <= !stat.bits_left;
		end else if (fire && ctrl.emit_sel == EM_PAD) begin
			duty <= '0;
			pad_count <= pad;
			half_full <= 1'b1;
			last <= 1'b1;
		end
	end

	`LBPE_ASSERT_NXT(a_last_bit, clk, arst_n, fire && ctrl.emit_sel == EM_BIT && !stat.bits_left, out_valid && last)
	`LBPE_ASSERT_NXT(a_pad_word, clk, arst_n, fire && ctrl.emit_sel == EM_PAD, pos_q == '0 && half_full && last)

endmodule

FILE: rtl/led_bit_pwm_encoder.sv
// LED bit encoder: turns LED color requests into one duty word per data bit.
// Input channel (in_valid/in_stall): action 0 carries three color bytes, action 1
// marks end of frame. Output channel (out_valid/out_stall): duty, pad_count,
// half_full, last. A request is taken on an edge with valid high and stall low.
// Each color byte is scaled by its temperature register and brightness, then
// sent MSB first, first byte first: 24 words, last set on the final one.
// End of frame gives one word with the zero-pad count up to the next half
// boundary of the transfer buffer.
// Datapath: a microcoded sequencer shares one 24x17 multiplier; each byte takes
// five steps (three products, reciprocal estimate, correction). An LED request
// scales all three bytes before its first word is sent; an end of frame goes
// from the idle step to the pad word step and back to idle.
// The block takes one request at a time; in_stall is high until it is done.
// A stalled output holds its word; the sequencer waits in the emit or end-of-frame step.
// Reset clears the position in the half, the sequencer and output valid, and
// loads the register defaults. Configuration is written with cfg_write.
module led_bit_pwm_encoder #(
	parameter int MAX_HALF_WORDS = lbpe_pkg::MAX_HALF_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [lbpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbpe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [lbpe_pkg::COLOR_W-1:0]   color_first,
	input  logic [lbpe_pkg::COLOR_W-1:0]   color_second,
	input  logic [lbpe_pkg::COLOR_W-1:0]   color_third,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lbpe_pkg::DUTY_W-1:0]    duty,
	output logic [lbpe_pkg::HALF_W-1:0]    pad_count,
	output logic                           half_full,
	output logic                           last
);
	import lbpe_pkg::*;

	logic [DUTY_W-1:0] duty_zero_q;
	logic [DUTY_W-1:0] duty_one_q;
	logic [7:0]        brightness_q;
	logic [7:0]        temp_first_q;
	logic [7:0]        temp_second_q;
	logic [7:0]        temp_third_q;
	logic [HALF_W-1:0] half_words_q;

	ctrl_t ctrl;
	stat_t stat;
	logic  fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_zero_q <= DUTY_ZERO_RST;
			duty_one_q <= DUTY_ONE_RST;
			brightness_q <= BRIGHT_RST;
			temp_first_q <= TEMP_RST;
			temp_second_q <= TEMP_RST;
			temp_third_q <= TEMP_RST;
			half_words_q <= HALF_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DUTY_ZERO:   duty_zero_q <= cfg_data[7:0];
				REG_DUTY_ONE:    duty_one_q <= cfg_data[7:0];
				REG_BRIGHTNESS:  brightness_q <= cfg_data[7:0];
				REG_TEMP_FIRST:  temp_first_q <= cfg_data[7:0];
				REG_TEMP_SECOND: temp_second_q <= cfg_data[7:0];
				REG_TEMP_THIRD:  temp_third_q <= cfg_data[7:0];
				REG_HALF_WORDS:  half_words_q <= cfg_data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (ctrl.wait_sel != WAIT_IN);

	lbpe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.fire   (fire)
	);

	lbpe_dp #(
		.MAX_HALF_WORDS (MAX_HALF_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.fire         (fire),
		.in_valid     (in_valid),
		.action       (action),
		.color_first  (color_first),
		.color_second (color_second),
		.color_third  (color_third),
		.duty_zero    (duty_zero_q),
		.duty_one     (duty_one_q),
		.brightness   (brightness_q),
		.temp_first   (temp_first_q),
		.temp_second  (temp_second_q),
		.temp_third   (temp_third_q),
		.half_words   (half_words_q),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.duty         (duty),
		.pad_count    (pad_count),
		.half_full    (half_full),
		.last         (last),
		.stat         (stat)
	);

endmodule
